// ===== rtl/mrq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_pkg
// Shared types and constants of the mux receive qualifier.
// ----------------------------------------------------------------------------
package mrq_pkg;

    localparam int LINE_W     = 4;
    localparam int UNIT_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int WORD_W     = 16;
    localparam int COUNT_W    = 16;
    localparam int ALARM_W    = 6;
    localparam int LCOUNT_W   = 8;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_LINES  = 16;

    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // silo word layout
    localparam int BIT_PRESENT = 15;
    localparam int BIT_OVERRUN = 14;
    localparam int BIT_FRAMING = 13;
    localparam int BIT_PARITY  = 12;

    localparam logic [COUNT_W-1:0] ALARM_HIGH_LIMIT = COUNT_W'(50);
    localparam logic [COUNT_W-1:0] ALARM_LOW_LIMIT  = COUNT_W'(16);
    localparam logic [ALARM_W-1:0] ALARM_HIGH       = ALARM_W'(32);
    localparam logic [ALARM_W-1:0] ALARM_LOW        = ALARM_W'(16);

    localparam logic [LCOUNT_W-1:0] LINE_COUNT_RST = LCOUNT_W'(16);
    localparam logic [CHAR_W-1:0]   INTR_CHAR_RST  = CHAR_W'(127);

    typedef enum logic [2:0] {
        KIND_DELIVER = 3'd0,
        KIND_WAKE    = 3'd1,
        KIND_PARITY  = 3'd2,
        KIND_NOLINE  = 3'd3,
        KIND_TICK    = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UNIT_NUMBER = 3'd0,
        REG_LINE_COUNT  = 3'd1,
        REG_OPEN_MASK   = 3'd2,
        REG_EVEN_MASK   = 3'd3,
        REG_ODD_MASK    = 3'd4,
        REG_RAW_MASK    = 3'd5,
        REG_INTR_CHAR   = 3'd6
    } cfg_reg_t;

    // classified item handed from front to back
    typedef struct packed {
        kind_t               kind;
        logic [LINE_W-1:0]   line;
        logic [CHAR_W-1:0]   ch;
        logic                overrun;
        logic                bump;
        logic [WORD_W-1:0]   word;
        logic [ALARM_W-1:0]  alarm;
    } mrq_task_t;

    typedef struct packed {
        kind_t               kind;
        logic [LINE_W-1:0]   line;
        logic [CHAR_W-1:0]   ch;
        logic                overrun;
        logic [COUNT_W-1:0]  error_count;
        logic [WORD_W-1:0]   last_error;
        logic [ALARM_W-1:0]  alarm;
    } mrq_result_t;

endpackage
`default_nettype wire

// ===== rtl/mrq_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mrq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mrq_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_front
// Holds configuration and the char counter, classifies each accepted item.
// ----------------------------------------------------------------------------
module mrq_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [mrq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mrq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             accept,
    input  wire logic                             func,
    input  wire logic [mrq_pkg::LINE_W-1:0]       rx_line,
    input  wire logic [mrq_pkg::CHAR_W-1:0]       rx_char,
    input  wire logic                             parity_error,
    input  wire logic                             framing_error,
    input  wire logic                             overrun_error,
    output mrq_pkg::mrq_task_t                    task_out
);
    import mrq_pkg::*;

    logic [UNIT_W-1:0]   unit_reg;
    logic [LCOUNT_W-1:0] line_count_reg;
    logic [MASK_W-1:0]   open_reg, even_reg, odd_reg, raw_reg;
    logic [CHAR_W-1:0]   intr_reg;
    logic [COUNT_W-1:0]  chars_reg, chars_next;

    logic [UNIT_W+LINE_W-1:0] glob;
    logic [WORD_W-1:0]        word, word_clr;
    logic [ALARM_W-1:0]       alarm;
    logic                     is_open, par_sel, raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg       <= '0;
            line_count_reg <= LINE_COUNT_RST;
            open_reg       <= '0;
            even_reg       <= '0;
            odd_reg        <= '0;
            raw_reg        <= '0;
            intr_reg       <= INTR_CHAR_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_UNIT_NUMBER: unit_reg       <= cfg_data[UNIT_W-1:0];
                REG_LINE_COUNT:  line_count_reg <= cfg_data[LCOUNT_W-1:0];
                REG_OPEN_MASK:   open_reg       <= cfg_data[MASK_W-1:0];
                REG_EVEN_MASK:   even_reg       <= cfg_data[MASK_W-1:0];
                REG_ODD_MASK:    odd_reg        <= cfg_data[MASK_W-1:0];
                REG_RAW_MASK:    raw_reg        <= cfg_data[MASK_W-1:0];
                REG_INTR_CHAR:   intr_reg       <= cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // char counter: every accepted word bumps it, an accepted tick clears it
    always_comb
    begin
        chars_next = chars_reg;
        if (accept)
        begin
            chars_next = func ? '0 : chars_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg <= '0;
        end
        else
        begin
            chars_reg <= chars_next;
        end
    end

    always_comb
    begin
        if (chars_reg > ALARM_HIGH_LIMIT)
        begin
            alarm = ALARM_HIGH;
        end
        else if (chars_reg > ALARM_LOW_LIMIT)
        begin
            alarm = ALARM_LOW;
        end
        else
        begin
            alarm = '0;
        end
    end

    assign glob    = {unit_reg, rx_line};
    assign is_open = open_reg[rx_line];
    assign par_sel = even_reg[rx_line] ^ odd_reg[rx_line];
    assign raw     = raw_reg[rx_line];
    assign word    = {1'b1, overrun_error, framing_error, parity_error, rx_line, rx_char};

    always_comb
    begin
        task_out       = '0;
        task_out.kind  = KIND_DELIVER;
        task_out.line  = rx_line;
        word_clr       = word;
        word_clr[BIT_PARITY] = 1'b0;
        if (framing_error)
        begin
            // break replaces the whole word
            word_clr = raw ? '0 : {{(WORD_W-CHAR_W){1'b0}}, intr_reg};
        end
        if (func)
        begin
            task_out.kind  = KIND_TICK;
            task_out.line  = '0;
            task_out.alarm = alarm;
        end
        else if ({1'b0, glob} >= line_count_reg)
        begin
            task_out.kind = KIND_NOLINE;
        end
        else if (!is_open)
        begin
            task_out.kind = KIND_WAKE;
        end
        else if (parity_error && par_sel)
        begin
            task_out.kind = KIND_PARITY;
            task_out.bump = 1'b1;
            task_out.word = word;
        end
        else
        begin
            task_out.ch      = word_clr[CHAR_W-1:0];
            task_out.overrun = word_clr[BIT_OVERRUN];
            task_out.bump    = word_clr[BIT_OVERRUN] | word_clr[BIT_FRAMING]
                             | word_clr[BIT_PARITY];
            task_out.word    = word_clr;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mrq_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrq_back
// Per-line error counters and saved error words, one update per cycle while the output queue has room.
// ----------------------------------------------------------------------------
module mrq_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 task_valid,
    input  mrq_pkg::mrq_task_t        task_in,
    input  wire logic                 res_full,
    output logic                      task_pop,
    output logic                      res_push,
    output mrq_pkg::mrq_result_t      res_out
);
    import mrq_pkg::*;

    logic [COUNT_W-1:0] errors_reg [NUM_LINES];
    logic [WORD_W-1:0]  last_reg   [NUM_LINES];
    logic [COUNT_W-1:0] count_next;
    logic [WORD_W-1:0]  last_next;
    logic               go, report;

    assign go       = task_valid && !res_full;
    assign task_pop = go;
    assign res_push = go;

    assign count_next = task_in.bump ? errors_reg[task_in.line] + 1'b1
                                     : errors_reg[task_in.line];
    assign last_next  = task_in.bump ? task_in.word : last_reg[task_in.line];
    assign report     = (task_in.kind == KIND_DELIVER) || (task_in.kind == KIND_PARITY);

    always_comb
    begin
        res_out             = '0;
        res_out.kind        = task_in.kind;
        res_out.line        = task_in.line;
        res_out.ch          = task_in.ch;
        res_out.overrun     = task_in.overrun;
        res_out.alarm       = task_in.alarm;
        if (report)
        begin
            res_out.error_count = count_next;
            res_out.last_error  = last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                errors_reg[i] <= '0;
                last_reg[i]   <= '0;
            end
        end
        else if (go && task_in.bump)
        begin
            errors_reg[task_in.line] <= count_next;
            last_reg[task_in.line]   <= last_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mux_receive_qualifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mux_receive_qualifier
// Receive-word qualifier for one 16-line serial multiplexer silo.
// ----------------------------------------------------------------------------
// Input side is a queue write port: an item (silo word or timer tick) is
// taken on a clock edge with push high and full low. Results are read like a
// queue: while empty is low the oldest result sits on the result ports and
// pop takes it. Every item gives exactly one result.
// Configuration is written through cfg_write/cfg_index/cfg_data, one
// register per cycle; the user must write it only while the block is idle, the block itself does not enforce this.
// The front classifies the item in its accept cycle and writes it into a
// two-entry queue; the back does the per-line error counter update and
// writes the result into a two-entry output queue. An item shows up on the
// result ports once it has passed the middle queue and the back into the
// output queue, and one item per cycle is sustained as long as pop keeps up,
// set by the single counter update of the back. When pop stays low the
// output queue fills, then the middle queue, and full rises; nothing is lost.
// Reset clears all queues, the error counters, the saved error words and
// the char counter, and loads the configuration reset values.
// ----------------------------------------------------------------------------
module mux_receive_qualifier #(
    parameter int MID_DEPTH = mrq_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = mrq_pkg::OUT_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [mrq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mrq_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             func,
    input  wire logic [mrq_pkg::LINE_W-1:0]       rx_line,
    input  wire logic [mrq_pkg::CHAR_W-1:0]       rx_char,
    input  wire logic                             parity_error,
    input  wire logic                             framing_error,
    input  wire logic                             overrun_error,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [2:0]                            kind,
    output logic [mrq_pkg::LINE_W-1:0]            out_line,
    output logic [mrq_pkg::CHAR_W-1:0]            out_char,
    output logic                                  out_overrun,
    output logic [mrq_pkg::COUNT_W-1:0]           error_count,
    output logic [mrq_pkg::WORD_W-1:0]            last_error,
    output logic [mrq_pkg::ALARM_W-1:0]           silo_alarm
);
    import mrq_pkg::*;

    localparam int TASK_W = $bits(mrq_task_t);
    localparam int RES_W  = $bits(mrq_result_t);

    mrq_task_t   task_new, task_head;
    mrq_result_t res_new, res_head;
    logic [TASK_W-1:0] task_rd;
    logic [RES_W-1:0]  res_rd;
    logic accept, mid_empty, task_pop, res_push, res_full;

    assign accept = push && !full;

    mrq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .func          (func),
        .rx_line       (rx_line),
        .rx_char       (rx_char),
        .parity_error  (parity_error),
        .framing_error (framing_error),
        .overrun_error (overrun_error),
        .task_out      (task_new)
    );

    mrq_fifo #(
        .WIDTH (TASK_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (TASK_W'(task_new)),
        .full  (full),
        .pop   (task_pop),
        .rdata (task_rd),
        .empty (mid_empty)
    );

    assign task_head = mrq_task_t'(task_rd);

    mrq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (!mid_empty),
        .task_in    (task_head),
        .res_full   (res_full),
        .task_pop   (task_pop),
        .res_push   (res_push),
        .res_out    (res_new)
    );

    mrq_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (RES_W'(res_new)),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rd),
        .empty (empty)
    );

    assign res_head    = mrq_result_t'(res_rd);
    assign kind        = res_head.kind;
    assign out_line    = res_head.line;
    assign out_char    = res_head.ch;
    assign out_overrun = res_head.overrun;
    assign error_count = res_head.error_count;
    assign last_error  = res_head.last_error;
    assign silo_alarm  = res_head.alarm;

endmodule
`default_nettype wire
